[design/sdc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdc_pkg
// Shared widths, register indexes, cadence codes and the compare result
// type for the step detector with cadence estimate.
// ---------------------------------------------------------------------------
package sdc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_WINDOW_DEPTH = 8;
    localparam int DEF_STEP_HISTORY = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SPAN_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_SPAN_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID_MS = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] AMP_LOW_RST      = 16'd140;
    localparam logic [CFG_W-1:0] AMP_HIGH_RST     = 16'd320;
    localparam logic [CFG_W-1:0] RUN_SPAN_MS_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] WALK_SPAN_MS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] MIN_VALID_MS_RST = 16'd100;

    typedef enum logic [2:0] {
        CAD_NOT_READY  = 3'd0,
        CAD_STATIONARY = 3'd1,
        CAD_WALKING    = 3'd2,
        CAD_RUNNING    = 3'd3,
        CAD_INVALID    = 3'd4
    } cadence_t;

    // Result of the shared subtract/compare unit.
    typedef struct packed {
        logic [TIME_W:0] diff;
        logic            lt;
        logic            eq;
    } sdc_cmp_t;

endpackage

[design/sdc_alu.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdc_alu
// Shared subtract and compare unit: a minus b on unsigned operands, with
// the signed difference and less-than and equal flags.
// ---------------------------------------------------------------------------
module sdc_alu (
    input  logic [sdc_pkg::TIME_W-1:0] a,
    input  logic [sdc_pkg::TIME_W-1:0] b,
    output sdc_pkg::sdc_cmp_t          res
);
    import sdc_pkg::*;

    logic [TIME_W:0] diff;

    assign diff     = {1'b0, a} - {1'b0, b};
    assign res.diff = diff;
    assign res.lt   = diff[TIME_W];
    assign res.eq   = (diff == '0);

endmodule

[design/sdc_window.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdc_window
// Sample window: a shift line of the last samples, a running sum and the
// truncated mean, formed by a reciprocal multiply.
// ---------------------------------------------------------------------------
module sdc_window #(
    parameter int DEPTH = sdc_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [sdc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [$clog2(DEPTH)-1:0]     rd_idx,
    output logic [sdc_pkg::SAMPLE_W-1:0] rd_data,
    output logic [sdc_pkg::SAMPLE_W-1:0] mean
);
    import sdc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = SAMPLE_W + IDX_W;
    localparam int SH    = SUM_W + IDX_W;
    localparam int RW    = SUM_W + 2;
    localparam int PW    = SUM_W + RW;
    // Rounded-up reciprocal of the depth; exact for every sum below 2**SUM_W.
    localparam logic [63:0]   RECIP_WIDE = ((64'd1 << SH) + DEPTH - 1) / DEPTH;
    localparam logic [RW-1:0] RECIP      = RECIP_WIDE[RW-1:0];

    logic [SAMPLE_W-1:0] win_reg [DEPTH];
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [PW-1:0]       prod;

    assign prod    = PW'(sum_reg) * PW'(RECIP);
    assign rd_data = win_reg[rd_idx];
    assign mean    = mean_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[DEPTH - 1] <= sample_in;
            sum_reg <= sum_reg + SUM_W'(sample_in) - SUM_W'(win_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= prod[SH +: SAMPLE_W];
    end

endmodule

[design/sdc_history.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdc_history
// Step time history: the newest entry takes each timestamp, and a detected
// step moves the entries one place toward the oldest.
// ---------------------------------------------------------------------------
module sdc_history #(
    parameter int DEPTH = sdc_pkg::DEF_STEP_HISTORY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load_now,
    input  logic [sdc_pkg::TIME_W-1:0] time_in,
    input  logic                       shift_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_idx,
    output logic [sdc_pkg::TIME_W-1:0] rd_data,
    output logic [sdc_pkg::TIME_W-1:0] t_first,
    output logic [sdc_pkg::TIME_W-1:0] t_last,
    output logic [sdc_pkg::TIME_W-1:0] t_prev
);
    import sdc_pkg::*;

    logic [TIME_W-1:0] t_reg [DEPTH];

    assign rd_data = t_reg[rd_idx];
    assign t_first = t_reg[0];
    assign t_last  = t_reg[DEPTH - 1];
    assign t_prev  = t_reg[DEPTH - 2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                t_reg[i] <= '0;
            end
        end
        else if (load_now)
        begin
            t_reg[DEPTH - 1] <= time_in;
        end
        else if (shift_en)
        begin
            // The newest entry already holds this sample's time and stays.
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                t_reg[i] <= t_reg[i + 1];
            end
        end
    end

endmodule

[design/step_detector_with_cadence.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// step_detector_with_cadence
// Step detector over a sliding sample window, with a cadence class taken
// from the spans between recent step times.
// ---------------------------------------------------------------------------
// Usage:
// A request carries one sample and its millisecond timestamp and is taken
// when in_valid is high and in_stall is low. Each request gives exactly one
// result (step_found, window_mean, cadence), offered with out_valid until
// taken at an edge where out_stall is low.
// One request is worked at a time; in_stall is high while it is in work.
// A small sequencer drives one shared subtract/compare unit: one mode check,
// STEP_HISTORY history checks and up to five span compares, plus the peak
// scan over the window and its threshold checks when a candidate matures.
// The result sits in an output register, so a new request is taken while
// the receiver stalls; the sequencer waits only if a second result is ready
// before the first was taken.
// Reset clears the window, the history and the detector and loads the
// default thresholds. Configuration is to be written only while idle.
// ---------------------------------------------------------------------------
module step_detector_with_cadence #(
    parameter int WINDOW_DEPTH = sdc_pkg::DEF_WINDOW_DEPTH,
    parameter int STEP_HISTORY = sdc_pkg::DEF_STEP_HISTORY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sdc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [sdc_pkg::TIME_W-1:0]    time_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          step_found,
    output logic [sdc_pkg::SAMPLE_W-1:0]  window_mean,
    output logic [2:0]                    cadence
);
    import sdc_pkg::*;

    localparam int WIDX_W = $clog2(WINDOW_DEPTH);
    localparam int HIDX_W = $clog2(STEP_HISTORY);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [WIDX_W-1:0] WIN_LAST  = WIDX_W'(WINDOW_DEPTH - 1);
    localparam logic [HIDX_W-1:0] HIST_LAST = HIDX_W'(STEP_HISTORY - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODE,
        ST_PEAK,
        ST_PEAK_LO,
        ST_PEAK_HI,
        ST_READY,
        ST_FULL,
        ST_FULL_CMP,
        ST_SPAN,
        ST_SPAN_RUN,
        ST_SPAN_WALK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_CANDIDATE = 2'd1,
        MODE_RECOVERY  = 2'd2
    } mode_t;

    state_t              state_reg,    state_next;
    mode_t               mode_reg,     mode_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    logic [CNT_W-1:0]    cnt_inc;
    logic [SAMPLE_W-1:0] sample_reg,   sample_next;
    logic [SAMPLE_W-1:0] peak_reg,     peak_next;
    logic [WIDX_W-1:0]   widx_reg,     widx_next;
    logic [HIDX_W-1:0]   hidx_reg,     hidx_next;
    logic [TIME_W-1:0]   diff_reg,     diff_next;
    logic                found_reg,    found_next;
    logic                nready_reg,   nready_next;
    cadence_t            cad_reg,      cad_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [SAMPLE_W-1:0] out_mean_reg,  out_mean_next;
    cadence_t            out_cad_reg,   out_cad_next;

    logic [CFG_W-1:0] amp_low_reg,  amp_low_next;
    logic [CFG_W-1:0] amp_high_reg, amp_high_next;
    logic [CFG_W-1:0] run_reg,      run_next;
    logic [CFG_W-1:0] walk_reg,     walk_next;
    logic [CFG_W-1:0] min_reg,      min_next;

    logic              accept;
    logic              hist_shift;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    sdc_cmp_t          cmp;
    logic [SAMPLE_W-1:0] win_rd;
    logic [SAMPLE_W-1:0] win_mean;
    logic [TIME_W-1:0] hist_rd;
    logic [TIME_W-1:0] t_first;
    logic [TIME_W-1:0] t_last;
    logic [TIME_W-1:0] t_prev;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign step_found  = out_found_reg;
    assign window_mean = out_mean_reg;
    assign cadence     = out_cad_reg;
    assign cnt_inc     = (cnt_reg < CNT_FULL) ? cnt_reg + 1'b1 : cnt_reg;

    sdc_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .sample_in (sample),
        .rd_idx    (widx_reg),
        .rd_data   (win_rd),
        .mean      (win_mean)
    );

    sdc_history #(
        .DEPTH (STEP_HISTORY)
    ) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_now (accept),
        .time_in  (time_ms),
        .shift_en (hist_shift),
        .rd_idx   (hidx_reg),
        .rd_data  (hist_rd),
        .t_first  (t_first),
        .t_last   (t_last),
        .t_prev   (t_prev)
    );

    sdc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (cmp)
    );

    // Operand selection for the shared compare unit.
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            ST_MODE:
            begin
                alu_a = TIME_W'(sample_reg);
                alu_b = TIME_W'(amp_low_reg);
            end
            ST_PEAK:
            begin
                alu_a = TIME_W'(peak_reg);
                alu_b = TIME_W'(win_rd);
            end
            ST_PEAK_LO:
            begin
                alu_a = TIME_W'(amp_low_reg);
                alu_b = TIME_W'(peak_reg);
            end
            ST_PEAK_HI:
            begin
                alu_a = TIME_W'(peak_reg);
                alu_b = TIME_W'(amp_high_reg);
            end
            ST_READY:
            begin
                alu_a = hist_rd;
                alu_b = TIME_W'(min_reg);
            end
            ST_FULL:
            begin
                alu_a = t_last;
                alu_b = t_first;
            end
            ST_FULL_CMP:
            begin
                alu_a = TIME_W'(walk_reg);
                alu_b = diff_reg;
            end
            ST_SPAN:
            begin
                alu_a = t_prev;
                alu_b = t_first;
            end
            ST_SPAN_RUN:
            begin
                alu_a = diff_reg;
                alu_b = TIME_W'(run_reg);
            end
            ST_SPAN_WALK:
            begin
                alu_a = diff_reg;
                alu_b = TIME_W'(walk_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        sample_next    = sample_reg;
        peak_next      = peak_reg;
        widx_next      = widx_reg;
        hidx_next      = hidx_reg;
        diff_next      = diff_reg;
        found_next     = found_reg;
        nready_next    = nready_reg;
        cad_next       = cad_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_mean_next  = out_mean_reg;
        out_cad_next   = out_cad_reg;
        hist_shift     = 1'b0;

        amp_low_next  = amp_low_reg;
        amp_high_next = amp_high_reg;
        run_next      = run_reg;
        walk_next     = walk_reg;
        min_next      = min_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AMP_LOW:      amp_low_next  = cfg_data;
                CFG_AMP_HIGH:     amp_high_next = cfg_data;
                CFG_RUN_SPAN_MS:  run_next      = cfg_data;
                CFG_WALK_SPAN_MS: walk_next     = cfg_data;
                CFG_MIN_VALID_MS: min_next      = cfg_data;
                default:          ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    state_next  = ST_MODE;
                end
            end
            ST_MODE:
            begin
                found_next  = 1'b0;
                nready_next = 1'b0;
                hidx_next   = '0;
                widx_next   = '0;
                peak_next   = '0;
                state_next  = ST_READY;
                unique case (mode_reg)
                    MODE_RECOVERY:
                    begin
                        if (cmp.lt)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_CANDIDATE:
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc == CNT_FULL)
                        begin
                            state_next = ST_PEAK;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_NORMAL;
                        if (!cmp.lt && !cmp.eq)
                        begin
                            mode_next = MODE_CANDIDATE;
                            cnt_next  = CNT_W'(1);
                        end
                    end
                endcase
            end
            ST_PEAK:
            begin
                if (cmp.lt)
                begin
                    peak_next = win_rd;
                end
                widx_next = widx_reg + 1'b1;
                if (widx_reg == WIN_LAST)
                begin
                    widx_next  = '0;
                    state_next = ST_PEAK_LO;
                end
            end
            ST_PEAK_LO:
            begin
                state_next = cmp.lt ? ST_PEAK_HI : ST_READY;
            end
            ST_PEAK_HI:
            begin
                if (cmp.lt)
                begin
                    found_next = 1'b1;
                    mode_next  = MODE_RECOVERY;
                    hist_shift = 1'b1;
                end
                state_next = ST_READY;
            end
            ST_READY:
            begin
                if (cmp.lt)
                begin
                    nready_next = 1'b1;
                end
                hidx_next = hidx_reg + 1'b1;
                if (hidx_reg == HIST_LAST)
                begin
                    hidx_next = '0;
                    if (nready_reg || cmp.lt)
                    begin
                        cad_next   = CAD_NOT_READY;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FULL;
                    end
                end
            end
            ST_FULL:
            begin
                diff_next = cmp.diff[TIME_W-1:0];
                if (cmp.lt)
                begin
                    cad_next   = CAD_STATIONARY;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FULL_CMP;
                end
            end
            ST_FULL_CMP:
            begin
                // The full span is above the walking limit when limit - span < 0.
                if (cmp.lt)
                begin
                    cad_next   = CAD_STATIONARY;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                diff_next = cmp.diff[TIME_W-1:0];
                if (cmp.lt)
                begin
                    cad_next   = CAD_INVALID;
                    state_next = ST_DONE;
                end
                else if (cmp.eq)
                begin
                    cad_next   = CAD_RUNNING;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SPAN_RUN;
                end
            end
            ST_SPAN_RUN:
            begin
                if (cmp.lt)
                begin
                    cad_next   = CAD_RUNNING;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SPAN_WALK;
                end
            end
            ST_SPAN_WALK:
            begin
                cad_next   = cmp.lt ? CAD_WALKING : CAD_STATIONARY;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_mean_next  = win_mean;
                    out_cad_next   = cad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_NORMAL;
            cnt_reg       <= '0;
            widx_reg      <= '0;
            hidx_reg      <= '0;
            found_reg     <= 1'b0;
            nready_reg    <= 1'b0;
            cad_reg       <= CAD_NOT_READY;
            out_valid_reg <= 1'b0;
            amp_low_reg   <= AMP_LOW_RST;
            amp_high_reg  <= AMP_HIGH_RST;
            run_reg       <= RUN_SPAN_MS_RST;
            walk_reg      <= WALK_SPAN_MS_RST;
            min_reg       <= MIN_VALID_MS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            widx_reg      <= widx_next;
            hidx_reg      <= hidx_next;
            found_reg     <= found_next;
            nready_reg    <= nready_next;
            cad_reg       <= cad_next;
            out_valid_reg <= out_valid_next;
            amp_low_reg   <= amp_low_next;
            amp_high_reg  <= amp_high_next;
            run_reg       <= run_next;
            walk_reg      <= walk_next;
            min_reg       <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        peak_reg      <= peak_next;
        diff_reg      <= diff_next;
        out_found_reg <= out_found_next;
        out_mean_reg  <= out_mean_next;
        out_cad_reg   <= out_cad_next;
    end

endmodule
